FILE: src/bfe_pkg.sv
package bfe_pkg;

    localparam int MAX_BITS_LOG2 = 16;
    localparam int MIN_BITS_LOG2 = 6;
    localparam int HASH_COUNT    = 4;
    localparam int HASH_IDX_W    = $clog2(HASH_COUNT);
    localparam int WORD_BITS     = 64;
    localparam int BIT_AW        = $clog2(WORD_BITS);
    localparam int IDX_W         = MAX_BITS_LOG2;
    localparam int WORD_AW       = MAX_BITS_LOG2 - BIT_AW;
    localparam int STORE_WORDS   = 1 << WORD_AW;
    localparam int CFG_W         = 5;
    localparam int COUNT_W       = 32;
    localparam int ONES_W        = MAX_BITS_LOG2 + 1;
    localparam int OUT_DEPTH     = 4;
    localparam int CREDIT_W      = $clog2(OUT_DEPTH + 1);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_STATUS = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] hash_a;
        logic [63:0] hash_b;
        logic [63:0] hash_c;
        logic [63:0] hash_d;
    } in_item_t;

    typedef struct packed {
        logic               maybe_present;
        logic [COUNT_W-1:0] items_added;
        logic [ONES_W-1:0]  bits_set;
    } out_item_t;

    typedef struct packed {
        logic [1:0]                           op;
        logic [HASH_COUNT-1:0][WORD_AW-1:0]   word_idx;
        logic [HASH_COUNT-1:0][BIT_AW-1:0]    bit_pos;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [WORD_AW-1:0] word_idx;
        logic [BIT_AW-1:0]  bit_pos;
        logic               first;
        logic               last;
        logic               emit;
    } beat_t;

endpackage

FILE: src/bfe_front.sv
module bfe_front
    import bfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  in_item_t         item,
    output cmd_t             cmd
);

    logic [IDX_W-1:0]   mask_reg;
    logic [IDX_W-1:0]   mask_next;
    logic [CFG_W-1:0]   act_log2;
    logic [IDX_W:0]     span;
    logic [63:0]        hashes [4];
    logic [IDX_W-1:0]   idx;

    assign cfg_ready = 1'b1;

    // Out-of-range sizes are pinned to the supported limits.
    always_comb
    begin
        if (cfg_data < CFG_W'(MIN_BITS_LOG2))
            act_log2 = CFG_W'(MIN_BITS_LOG2);
        else if (cfg_data > CFG_W'(MAX_BITS_LOG2))
            act_log2 = CFG_W'(MAX_BITS_LOG2);
        else
            act_log2 = cfg_data;
        span      = (IDX_W+1)'(1) << act_log2;
        mask_next = IDX_W'(span - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '1;
        else if (cfg_valid && cfg_ready)
            mask_reg <= mask_next;
    end

    assign hashes[0] = item.hash_a;
    assign hashes[1] = item.hash_b;
    assign hashes[2] = item.hash_c;
    assign hashes[3] = item.hash_d;

    always_comb
    begin
        cmd    = '0;
        idx    = '0;
        cmd.op = item.opcode;
        for (int i = 0; i < HASH_COUNT; i++)
        begin
            idx             = hashes[i % 4][IDX_W-1:0] & mask_reg;
            cmd.word_idx[i] = idx[IDX_W-1:BIT_AW];
            cmd.bit_pos[i]  = idx[BIT_AW-1:0];
        end
    end

endmodule

FILE: src/bfe_cmd_queue.sv
module bfe_cmd_queue
    import bfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic q_full,
    input  logic pop,
    output cmd_t head,
    output logic q_empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

FILE: src/bfe_res_queue.sv
module bfe_res_queue
    import bfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      q_full,
    input  logic      pop,
    output out_item_t head,
    output logic      q_empty
);

    localparam int PTR_W = $clog2(OUT_DEPTH);

    out_item_t         slot_reg [OUT_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;

    assign q_full  = (count_reg == (PTR_W+1)'(OUT_DEPTH));
    assign q_empty = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: src/bfe_back.sv
module bfe_back
    import bfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    input  logic      res_taken,
    output logic      init_busy,
    output logic      res_push,
    output out_item_t res_item
);

    localparam logic [WORD_AW-1:0]    WORD_LAST = WORD_AW'(STORE_WORDS - 1);
    localparam logic [HASH_IDX_W-1:0] HASH_LAST = HASH_IDX_W'(HASH_COUNT - 1);

    logic [WORD_BITS-1:0] mem [STORE_WORDS];

    logic                  init_reg;
    logic                  init_next;
    logic [WORD_AW-1:0]    cnt_reg;
    logic [WORD_AW-1:0]    cnt_next;
    logic [CREDIT_W-1:0]   inflight_reg;
    logic [CREDIT_W-1:0]   inflight_next;
    logic [HASH_IDX_W-1:0] hidx;
    logic                  start;
    logic                  a_valid;
    beat_t                 a_beat;

    logic                  b_valid_reg;
    beat_t                 b_beat_reg;
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  fwd_valid_reg;
    logic [WORD_AW-1:0]    fwd_addr_reg;
    logic [WORD_BITS-1:0]  fwd_data_reg;
    logic [COUNT_W-1:0]    added_reg;
    logic [COUNT_W-1:0]    added_next;
    logic [ONES_W-1:0]     ones_reg;
    logic [ONES_W-1:0]     ones_next;
    logic                  present_reg;
    logic                  present_next;

    logic [WORD_BITS-1:0]  eff_data;
    logic                  was_set;
    logic                  wr_en;
    logic [WORD_BITS-1:0]  wr_data;

    assign init_busy = init_reg;
    assign hidx      = cnt_reg[HASH_IDX_W-1:0];

    // Issue stage: one memory read per cycle while a command waits and a result place is free;
    // an add or query takes one beat per hash, a clear one beat per store word, a status a single beat.
    always_comb
    begin
        a_beat    = '0;
        a_valid   = 1'b0;
        cmd_pop   = 1'b0;
        start     = 1'b0;
        cnt_next  = cnt_reg;
        init_next = init_reg;
        if (init_reg)
        begin
            a_valid         = 1'b1;
            a_beat.op       = OP_CLEAR;
            a_beat.word_idx = cnt_reg;
            a_beat.first    = (cnt_reg == '0);
            a_beat.last     = (cnt_reg == WORD_LAST);
            a_beat.emit     = 1'b0;
            cnt_next        = a_beat.last ? '0 : cnt_reg + 1'b1;
            init_next       = !a_beat.last;
        end
        else if (!cmd_empty &&
                 (cnt_reg != '0 || inflight_reg < CREDIT_W'(OUT_DEPTH)))
        begin
            a_valid      = 1'b1;
            a_beat.op    = cmd.op;
            a_beat.first = (cnt_reg == '0);
            a_beat.emit  = 1'b1;
            start        = a_beat.first;
            unique case (cmd.op)
                OP_ADD, OP_QUERY:
                begin
                    a_beat.word_idx = cmd.word_idx[hidx];
                    a_beat.bit_pos  = cmd.bit_pos[hidx];
                    a_beat.last     = (hidx == HASH_LAST);
                end
                OP_CLEAR:
                begin
                    a_beat.word_idx = cnt_reg;
                    a_beat.last     = (cnt_reg == WORD_LAST);
                end
                OP_STATUS:
                begin
                    a_beat.last = 1'b1;
                end
            endcase
            cnt_next = a_beat.last ? '0 : cnt_reg + 1'b1;
            cmd_pop  = a_beat.last;
        end
    end

    // Every item that will give a result holds a place in the result queue.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (start && !res_taken)
            inflight_next = inflight_reg + 1'b1;
        else if (res_taken && !start)
            inflight_next = inflight_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[b_beat_reg.word_idx] <= wr_data;
        if (a_valid)
            rd_data_reg <= mem[a_beat.word_idx];
    end

    // The read issued alongside a write returns the old word, so the word written
    // in the previous cycle is forwarded.
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == b_beat_reg.word_idx)
            eff_data = fwd_data_reg;
        else
            eff_data = rd_data_reg;
        was_set = eff_data[b_beat_reg.bit_pos];
    end

    always_comb
    begin
        wr_en        = 1'b0;
        wr_data      = eff_data;
        added_next   = added_reg;
        ones_next    = ones_reg;
        present_next = present_reg;
        if (b_valid_reg)
        begin
            unique case (b_beat_reg.op)
                OP_ADD:
                begin
                    wr_en   = 1'b1;
                    wr_data = eff_data | (WORD_BITS'(1) << b_beat_reg.bit_pos);
                    if (!was_set)
                        ones_next = ones_reg + 1'b1;
                    if (b_beat_reg.last && added_reg != '1)
                        added_next = added_reg + 1'b1;
                end
                OP_QUERY:
                begin
                    present_next = (b_beat_reg.first || present_reg) && was_set;
                end
                OP_CLEAR:
                begin
                    wr_en   = 1'b1;
                    wr_data = '0;
                    if (b_beat_reg.last)
                    begin
                        added_next = '0;
                        ones_next  = '0;
                    end
                end
                OP_STATUS:
                begin
                end
            endcase
        end
    end

    assign res_push               = b_valid_reg && b_beat_reg.last && b_beat_reg.emit;
    assign res_item.maybe_present = (b_beat_reg.op == OP_QUERY) && present_next;
    assign res_item.items_added   = added_next;
    assign res_item.bits_set      = ones_next;

    always_ff @(posedge clk)
    begin
        b_beat_reg   <= a_beat;
        fwd_addr_reg <= b_beat_reg.word_idx;
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= 1'b1;
            cnt_reg       <= '0;
            inflight_reg  <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            added_reg     <= '0;
            ones_reg      <= '0;
            present_reg   <= 1'b0;
        end
        else
        begin
            init_reg      <= init_next;
            cnt_reg       <= cnt_next;
            inflight_reg  <= inflight_next;
            b_valid_reg   <= a_valid;
            fwd_valid_reg <= wr_en;
            added_reg     <= added_next;
            ones_reg      <= ones_next;
            present_reg   <= present_next;
        end
    end

endmodule

FILE: src/bloom_filter_engine.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------
// item     | push / full        | in_item_t: opcode, hash_a .. hash_d
// result   | pop / empty        | out_item_t: maybe_present, items_added,
//          |                    |   bits_set
// cfg      | cfg_valid/cfg_ready| cfg_data: size_log2
//
// Add and query items issue one store read per hash and follow one another
// without gaps while a result place is free; a status item issues one read and
// a clear walks all 1024 store words at one per cycle. A result is pushed from
// the registered stage that handles an item's last beat. After reset the store
// is zeroed word by word in a pass during which full stays high. The result
// queue holds 4 items; the engine stalls on its own when they are all taken
// up, and the 2-entry command queue then fills.
module bloom_filter_engine
    import bfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  in_item_t         item,
    output logic             empty,
    input  logic             pop,
    output out_item_t        result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    cmd_t      front_cmd;
    cmd_t      head_cmd;
    logic      cmd_push;
    logic      cmd_full;
    logic      cmd_pop;
    logic      cmd_empty;
    logic      init_busy;
    logic      res_push;
    logic      res_full;
    logic      res_taken;
    out_item_t res_item;

    assign full      = cmd_full || init_busy;
    assign cmd_push  = push && !full;
    assign res_taken = pop && !empty;

    bfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (front_cmd)
    );

    bfe_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (front_cmd),
        .q_full   (cmd_full),
        .pop      (cmd_pop),
        .head     (head_cmd),
        .q_empty  (cmd_empty)
    );

    bfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_taken (res_taken),
        .init_busy (init_busy),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    bfe_res_queue u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_item (res_item),
        .q_full    (res_full),
        .pop       (res_taken),
        .head      (result),
        .q_empty   (empty)
    );

`ifndef NO_ASSERTIONS
    a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> full)
        else $error("item could be taken during the store clearing pass");

    a_result_credit: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full result queue");

    a_cmd_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty && !init_busy)
        else $error("command popped with none waiting");
`endif

endmodule
